// ----- sv/pts_pkg.sv -----
package pts_pkg;

  localparam int SINE_DEPTH_DEFAULT = 1024;
  localparam int EXP_DEPTH_DEFAULT  = 1024;

  // Fixed field widths
  localparam int FREQ_W  = 15;
  localparam int AMP_W   = 16;
  localparam int RATE_W  = 17;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 17;

  // Datapath widths
  localparam int TQ_W    = 20;
  localparam int FT_W    = FREQ_W + TQ_W;
  localparam int MA_W    = 36;
  localparam int MB_W    = 26;
  localparam int MP_W    = MA_W + MB_W;
  localparam int Y_W     = 20;
  localparam int U_W     = 20;
  localparam int DIV_STEPS = TQ_W;
  localparam int DCNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_TONE_FREQ   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_AMPLITUDE   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;
  localparam logic [IDX_W-1:0] CFG_WIDTH_MODE  = 2'd3;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 15'd440;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd32768;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;

  // Fixed-point constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned INV_E_Q30   = 64'd395007542;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam logic [19:0] TREM_TURNS_Q16  = 20'd730126;
  localparam logic [15:0] CUBE_COEF       = 16'd13107;
  localparam logic [15:0] TREM_DEPTH      = 16'd6554;
  localparam logic signed [17:0] TREM_BASE = 18'sd58982;
  localparam logic [4:0]  ATTACK_RATE     = 5'd22;
  localparam int NUM_HARM = 3;

  localparam logic [15:0] HARM_GAIN [NUM_HARM] = '{16'd39322, 16'd19661, 16'd6554};
  localparam logic [24:0] HARM_DECAY [NUM_HARM] =
    '{25'd10794430, 25'd13493038, 25'd20239557};

  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq;
    logic [AMP_W-1:0]  amplitude;
    logic [RATE_W-1:0] sample_rate;
    logic              sample_width_mode;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_FT, ST_H_DEC, ST_H_LOOK, ST_H_GS, ST_H_GSE,
    ST_TREM, ST_COS, ST_GAIN, ST_ATT, ST_ATT_LOOK, ST_Y2, ST_Y3, ST_YC,
    ST_YG, ST_YA, ST_AMP, ST_MAXV, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_DIV, OP_FT, OP_DEC, OP_LOOK, OP_GS, OP_GSE,
    OP_TREM, OP_COS, OP_GAIN, OP_ATT, OP_Y2, OP_Y3, OP_YC, OP_YG, OP_YA,
    OP_AMP, OP_MAXV, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] harm;
  } cmd_t;

  // Quarter-wave sine entry, Q1.15, from angle x in Q30
  function automatic logic [15:0] sine_entry(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    // Odd terms x^(2k+1)/(2k+1)!, alternating sign
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    v = (longint'(sum) + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return v[15:0];
  endfunction

  // e^-x entry, Q1.15, from x in Q30
  function automatic logic [15:0] exp_entry(input longint unsigned x);
    longint unsigned m;
    longint unsigned r;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    m    = x >> 30;
    r    = x & (ONE_Q30 - 64'd1);
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    // Terms r^k/k! of the fractional part, alternating sign
    term = (term * r) >> 30;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd2;
    sum  = sum + longint'(term);
    term = ((term * r) >> 30) / 64'd3;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd4;
    sum  = sum + longint'(term);
    term = ((term * r) >> 30) / 64'd5;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd6;
    sum  = sum + longint'(term);
    term = ((term * r) >> 30) / 64'd7;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd8;
    sum  = sum + longint'(term);
    term = ((term * r) >> 30) / 64'd9;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd10;
    sum  = sum + longint'(term);
    term = ((term * r) >> 30) / 64'd11;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd12;
    sum  = sum + longint'(term);
    term = ((term * r) >> 30) / 64'd13;
    sum  = sum - longint'(term);
    term = ((term * r) >> 30) / 64'd14;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    v = longint'(sum);
    for (int j = 0; j < 16; j++) begin
      if (longint'(j) < m) v = (v * INV_E_Q30) >> 30;
    end
    v = (v + 64'd16384) >> 15;
    return v[15:0];
  endfunction

endpackage

// ----- sv/piano_tone_synthesizer.sv -----
// Piano-like tone generator: every accepted input beat yields one PCM sample beat at
// t = n / sample_rate, built from three decaying harmonics, a cubic shaping term, a
// tremolo and an attack boost, clamped to 0..1 and scaled by amplitude and sample width.
// Each sample runs through these steps before the next beat can be accepted: a 20-step
// restoring divider forms t, then 25 steps drive the shared multiplier and the table
// lookups one per cycle, the done state moves the sample into the output register and
// the idle state takes the next beat. That handoff waits only while the previous sample
// still sits stalled in the output register. The finished sample waits there, so the next
// input beat is accepted while the previous sample is still stalled.
// Configuration writes are always ready and must be issued only while no sample is in work.
module piano_tone_synthesizer #(
  parameter int SINE_TABLE_DEPTH = pts_pkg::SINE_DEPTH_DEFAULT,
  parameter int EXP_TABLE_DEPTH  = pts_pkg::EXP_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pts_pkg::VAL_W-1:0]    out_sample_value,
  output logic [pts_pkg::RATE_W-1:0]   out_sample_index,
  output logic                         out_last_of_buffer,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pts_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pts_pkg::DATA_W-1:0]   cfg_data
);

  pts_pkg::cfg_t cfg_r;
  pts_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Register file: write the addressed field, hold the rest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tone_freq         <= pts_pkg::FREQ_RESET;
      cfg_r.amplitude         <= pts_pkg::AMP_RESET;
      cfg_r.sample_rate       <= pts_pkg::RATE_RESET;
      cfg_r.sample_width_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pts_pkg::CFG_TONE_FREQ:   cfg_r.tone_freq   <= cfg_data[pts_pkg::FREQ_W-1:0];
        pts_pkg::CFG_AMPLITUDE:   cfg_r.amplitude   <= cfg_data[pts_pkg::AMP_W-1:0];
        pts_pkg::CFG_SAMPLE_RATE: cfg_r.sample_rate <= cfg_data[pts_pkg::RATE_W-1:0];
        pts_pkg::CFG_WIDTH_MODE:  cfg_r.sample_width_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: steps the datapath through one sample per input beat
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Divider, shared multiplier, sine and exponential tables, output register
  pts_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_restart         (in_restart),
    .out_sample_value   (out_sample_value),
    .out_sample_index   (out_sample_index),
    .out_last_of_buffer (out_last_of_buffer)
  );

endmodule

// ----- sv/pts_ctrl.sv -----
module pts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output pts_pkg::cmd_t  cmd
);

  pts_pkg::state_t state_r, state_nxt;
  logic [pts_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [1:0] harm_r, harm_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pts_pkg::ST_IDLE;
      dcnt_r      <= '0;
      harm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      harm_r      <= harm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and sequence counters
  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    harm_nxt  = harm_r;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        dcnt_nxt = '0;
        harm_nxt = '0;
        if (in_valid) state_nxt = pts_pkg::ST_DIV;
      end
      pts_pkg::ST_DIV: begin
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == pts_pkg::DCNT_W'(pts_pkg::DIV_STEPS - 1)) state_nxt = pts_pkg::ST_FT;
      end
      pts_pkg::ST_FT:     state_nxt = pts_pkg::ST_H_DEC;
      pts_pkg::ST_H_DEC:  state_nxt = pts_pkg::ST_H_LOOK;
      pts_pkg::ST_H_LOOK: state_nxt = pts_pkg::ST_H_GS;
      pts_pkg::ST_H_GS:   state_nxt = pts_pkg::ST_H_GSE;
      pts_pkg::ST_H_GSE: begin
        if (harm_r == 2'(pts_pkg::NUM_HARM - 1)) begin
          state_nxt = pts_pkg::ST_TREM;
        end else begin
          harm_nxt  = harm_r + 1'b1;
          state_nxt = pts_pkg::ST_H_DEC;
        end
      end
      pts_pkg::ST_TREM:     state_nxt = pts_pkg::ST_COS;
      pts_pkg::ST_COS:      state_nxt = pts_pkg::ST_GAIN;
      pts_pkg::ST_GAIN:     state_nxt = pts_pkg::ST_ATT;
      pts_pkg::ST_ATT:      state_nxt = pts_pkg::ST_ATT_LOOK;
      pts_pkg::ST_ATT_LOOK: state_nxt = pts_pkg::ST_Y2;
      pts_pkg::ST_Y2:       state_nxt = pts_pkg::ST_Y3;
      pts_pkg::ST_Y3:       state_nxt = pts_pkg::ST_YC;
      pts_pkg::ST_YC:       state_nxt = pts_pkg::ST_YG;
      pts_pkg::ST_YG:       state_nxt = pts_pkg::ST_YA;
      pts_pkg::ST_YA:       state_nxt = pts_pkg::ST_AMP;
      pts_pkg::ST_AMP:      state_nxt = pts_pkg::ST_MAXV;
      pts_pkg::ST_MAXV:     state_nxt = pts_pkg::ST_DONE;
      pts_pkg::ST_DONE: begin
        if (out_free) state_nxt = pts_pkg::ST_IDLE;
      end
      default: state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd.op        = pts_pkg::OP_IDLE;
    cmd.harm      = harm_r;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = pts_pkg::OP_LOAD;
      end
      pts_pkg::ST_DIV:      cmd.op = pts_pkg::OP_DIV;
      pts_pkg::ST_FT:       cmd.op = pts_pkg::OP_FT;
      pts_pkg::ST_H_DEC:    cmd.op = pts_pkg::OP_DEC;
      pts_pkg::ST_H_LOOK:   cmd.op = pts_pkg::OP_LOOK;
      pts_pkg::ST_H_GS:     cmd.op = pts_pkg::OP_GS;
      pts_pkg::ST_H_GSE:    cmd.op = pts_pkg::OP_GSE;
      pts_pkg::ST_TREM:     cmd.op = pts_pkg::OP_TREM;
      pts_pkg::ST_COS:      cmd.op = pts_pkg::OP_COS;
      pts_pkg::ST_GAIN:     cmd.op = pts_pkg::OP_GAIN;
      pts_pkg::ST_ATT:      cmd.op = pts_pkg::OP_ATT;
      pts_pkg::ST_ATT_LOOK: cmd.op = pts_pkg::OP_LOOK;
      pts_pkg::ST_Y2:       cmd.op = pts_pkg::OP_Y2;
      pts_pkg::ST_Y3:       cmd.op = pts_pkg::OP_Y3;
      pts_pkg::ST_YC:       cmd.op = pts_pkg::OP_YC;
      pts_pkg::ST_YG:       cmd.op = pts_pkg::OP_YG;
      pts_pkg::ST_YA:       cmd.op = pts_pkg::OP_YA;
      pts_pkg::ST_AMP:      cmd.op = pts_pkg::OP_AMP;
      pts_pkg::ST_MAXV:     cmd.op = pts_pkg::OP_MAXV;
      pts_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op        = pts_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = pts_pkg::OP_IDLE;
    endcase
  end

endmodule

// ----- sv/pts_datapath.sv -----
module pts_datapath #(
  parameter int SINE_TABLE_DEPTH = pts_pkg::SINE_DEPTH_DEFAULT,
  parameter int EXP_TABLE_DEPTH  = pts_pkg::EXP_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pts_pkg::cmd_t               cmd,
  input  pts_pkg::cfg_t               cfg,
  input  logic                        in_restart,
  output logic [pts_pkg::VAL_W-1:0]   out_sample_value,
  output logic [pts_pkg::RATE_W-1:0]  out_sample_index,
  output logic                        out_last_of_buffer
);

  localparam int SW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int EW  = $clog2(EXP_TABLE_DEPTH);
  localparam int SPW = 14 + SW;
  localparam int EPW = pts_pkg::U_W + EW + 1;
  localparam int RW  = pts_pkg::RATE_W;

  // Constant lookup tables
  logic [15:0] sin_tab [SINE_TABLE_DEPTH + 1];
  logic [15:0] exp_tab [EXP_TABLE_DEPTH];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_sin
    localparam longint unsigned SX =
      (pts_pkg::HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
    assign sin_tab[i] = pts_pkg::sine_entry(SX);
  end

  for (genvar j = 0; j < EXP_TABLE_DEPTH; j++) begin : g_exp
    localparam longint unsigned EX = (longint'(j) << 34) / EXP_TABLE_DEPTH;
    assign exp_tab[j] = pts_pkg::exp_entry(EX);
  end

  logic [RW-1:0]                cnt_r;
  logic [RW-1:0]                n_r;
  logic                         last_r;
  logic [RW:0]                  rem_r;
  logic [pts_pkg::TQ_W-1:0]     q_r;
  logic [pts_pkg::FT_W-1:0]     ft_r;
  logic [pts_pkg::U_W-1:0]      u_r;
  logic                         uovf_r;
  logic signed [16:0]           sin_r;
  logic [15:0]                  exp_r;
  logic signed [33:0]           gs_r;
  logic signed [pts_pkg::Y_W-1:0] y_r;
  logic signed [pts_pkg::Y_W-1:0] y3_r;
  logic [15:0]                  trem_r;
  logic signed [17:0]           gain_r;
  logic [32:0]                  ga_r;
  logic [pts_pkg::VAL_W-1:0]    val_r;
  logic [pts_pkg::VAL_W-1:0]    out_val_r;
  logic [RW-1:0]                out_idx_r;
  logic                         out_last_r;

  logic [RW-1:0]                n_sel;
  logic [RW:0]                  n_inc;
  logic [RW:0]                  rem2;
  logic                         rem_ge;
  logic signed [pts_pkg::MA_W-1:0] ma;
  logic signed [pts_pkg::MB_W-1:0] mb;
  logic signed [pts_pkg::MP_W-1:0] mp;
  logic [15:0]                  phase;
  logic [SPW-1:0]               sprod;
  logic [SW-1:0]                sidx;
  logic [SW-1:0]                saddr;
  logic [EPW-1:0]               eprod;
  logic [EW-1:0]                eaddr;
  logic [24:0]                  att_prod;
  logic signed [pts_pkg::Y_W:0] ysum;
  logic signed [pts_pkg::Y_W-1:0] yclamp;

  // Sample position and wrap
  assign n_sel = (in_restart || (cnt_r >= cfg.sample_rate)) ? '0 : cnt_r;
  assign n_inc = {1'b0, n_sel} + 1'b1;

  // One restoring step of t = n * 2^20 / rate
  assign rem2   = {rem_r[RW-1:0], 1'b0};
  assign rem_ge = (cfg.sample_rate != '0) && (rem2 >= {1'b0, cfg.sample_rate});

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      pts_pkg::OP_FT: begin
        ma = pts_pkg::MA_W'(signed'({1'b0, cfg.tone_freq}));
        mb = pts_pkg::MB_W'(signed'({1'b0, q_r}));
      end
      pts_pkg::OP_DEC: begin
        ma = pts_pkg::MA_W'(signed'({1'b0, ft_r}));
        mb = pts_pkg::MB_W'(signed'({1'b0, pts_pkg::HARM_DECAY[cmd.harm]}));
      end
      pts_pkg::OP_GS: begin
        ma = pts_pkg::MA_W'(signed'({1'b0, pts_pkg::HARM_GAIN[cmd.harm]}));
        mb = pts_pkg::MB_W'(sin_r);
      end
      pts_pkg::OP_GSE: begin
        ma = pts_pkg::MA_W'(gs_r);
        mb = pts_pkg::MB_W'(signed'({1'b0, exp_r}));
      end
      pts_pkg::OP_TREM: begin
        ma = pts_pkg::MA_W'(signed'({1'b0, q_r}));
        mb = pts_pkg::MB_W'(signed'({1'b0, pts_pkg::TREM_TURNS_Q16}));
      end
      pts_pkg::OP_GAIN: begin
        ma = pts_pkg::MA_W'(signed'({1'b0, pts_pkg::TREM_DEPTH}));
        mb = pts_pkg::MB_W'(sin_r);
      end
      pts_pkg::OP_Y2: begin
        ma = pts_pkg::MA_W'(y_r);
        mb = pts_pkg::MB_W'(y_r);
      end
      pts_pkg::OP_Y3: begin
        ma = pts_pkg::MA_W'(y3_r);
        mb = pts_pkg::MB_W'(y_r);
      end
      pts_pkg::OP_YC: begin
        ma = pts_pkg::MA_W'(y3_r);
        mb = pts_pkg::MB_W'(signed'({1'b0, pts_pkg::CUBE_COEF}));
      end
      pts_pkg::OP_YG: begin
        ma = pts_pkg::MA_W'(y_r);
        mb = pts_pkg::MB_W'(gain_r);
      end
      pts_pkg::OP_YA: begin
        ma = pts_pkg::MA_W'(y_r);
        mb = pts_pkg::MB_W'(signed'({1'b0, exp_r}));
      end
      pts_pkg::OP_AMP: begin
        ma = pts_pkg::MA_W'(y_r);
        mb = pts_pkg::MB_W'(signed'({1'b0, cfg.amplitude}));
      end
      pts_pkg::OP_MAXV: begin
        ma = pts_pkg::MA_W'(signed'({1'b0, ga_r}));
        mb = cfg.sample_width_mode ? pts_pkg::MB_W'(17'sd65535) : pts_pkg::MB_W'(17'sd255);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp = ma * mb;

  // Phase for the sine table: harmonic k uses (2^k * ft) >> 5, cosine adds a quarter turn
  always_comb begin
    case (cmd.op)
      pts_pkg::OP_COS: phase = trem_r + 16'h4000;
      default: begin
        case (cmd.harm)
          2'd1:    phase = ft_r[19:4];
          2'd2:    phase = ft_r[18:3];
          default: phase = ft_r[20:5];
        endcase
      end
    endcase
  end

  assign sprod = SPW'(phase[13:0]) * SPW'(SINE_TABLE_DEPTH);
  assign sidx  = SW'(sprod >> 14);
  assign saddr = phase[14] ? (SW'(SINE_TABLE_DEPTH) - sidx) : sidx;

  assign eprod = EPW'(u_r) * EPW'(EXP_TABLE_DEPTH);
  assign eaddr = EW'(eprod >> pts_pkg::U_W);

  assign att_prod = 25'(q_r) * 25'(pts_pkg::ATTACK_RATE);

  // Attack add and clamp to 0..1
  assign ysum = (pts_pkg::Y_W + 1)'(y_r) + (pts_pkg::Y_W + 1)'(mp >>> 14);
  always_comb begin
    if (ysum > (pts_pkg::Y_W + 1)'(65536)) yclamp = pts_pkg::Y_W'(65536);
    else if (ysum < 0) yclamp = '0;
    else yclamp = pts_pkg::Y_W'(ysum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.op == pts_pkg::OP_LOAD) begin
      cnt_r <= (n_inc >= {1'b0, cfg.sample_rate}) ? '0 : n_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pts_pkg::OP_LOAD: begin
        n_r    <= n_sel;
        last_r <= n_inc >= {1'b0, cfg.sample_rate};
        rem_r  <= {1'b0, n_sel};
        q_r    <= '0;
        y_r    <= '0;
      end
      pts_pkg::OP_DIV: begin
        rem_r <= rem_ge ? (rem2 - {1'b0, cfg.sample_rate}) : rem2;
        q_r   <= {q_r[pts_pkg::TQ_W-2:0], rem_ge};
      end
      pts_pkg::OP_FT: ft_r <= mp[pts_pkg::FT_W-1:0];
      pts_pkg::OP_DEC: begin
        u_r    <= mp[36 +: pts_pkg::U_W];
        uovf_r <= |mp[pts_pkg::MP_W-1:36 + pts_pkg::U_W];
        sin_r  <= phase[15] ? -signed'({1'b0, sin_tab[saddr]})
                            : signed'({1'b0, sin_tab[saddr]});
      end
      pts_pkg::OP_LOOK: exp_r <= uovf_r ? '0 : exp_tab[eaddr];
      pts_pkg::OP_GS:   gs_r  <= 34'(mp);
      pts_pkg::OP_GSE:  y_r   <= y_r + pts_pkg::Y_W'(mp >>> 30);
      pts_pkg::OP_TREM: trem_r <= mp[35:20];
      pts_pkg::OP_COS: begin
        sin_r <= phase[15] ? -signed'({1'b0, sin_tab[saddr]})
                           : signed'({1'b0, sin_tab[saddr]});
      end
      pts_pkg::OP_GAIN: gain_r <= pts_pkg::TREM_BASE + 18'(mp >>> 15);
      pts_pkg::OP_ATT: begin
        u_r    <= att_prod[23:4];
        uovf_r <= att_prod[24];
      end
      pts_pkg::OP_Y2:   y3_r <= pts_pkg::Y_W'(mp >>> 16);
      pts_pkg::OP_Y3:   y3_r <= pts_pkg::Y_W'(mp >>> 16);
      pts_pkg::OP_YC:   y_r  <= y_r + pts_pkg::Y_W'(mp >>> 16);
      pts_pkg::OP_YG:   y_r  <= pts_pkg::Y_W'(mp >>> 16);
      pts_pkg::OP_YA:   y_r  <= yclamp;
      pts_pkg::OP_AMP:  ga_r <= mp[32:0];
      pts_pkg::OP_MAXV: val_r <= mp[47:32];
      pts_pkg::OP_OUT: begin
        out_val_r  <= val_r;
        out_idx_r  <= n_r;
        out_last_r <= last_r;
      end
      default: ;
    endcase
  end

  assign out_sample_value   = out_val_r;
  assign out_sample_index   = out_idx_r;
  assign out_last_of_buffer = out_last_r;

endmodule
